// ===== src/uart_8250_register_file_defines.svh =====
// Assertion macros for the register file checker.
`ifndef UART_8250_REGISTER_FILE_DEFINES_SVH
`define UART_8250_REGISTER_FILE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define URF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("register file check failed");

// Next-cycle implication, disabled while in reset.
`define URF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("register file check failed");

`endif

// ===== src/urf_pkg.sv =====
// Shared types and constants for the 8250 register file.
package urf_pkg;

    localparam logic [15:0] WINDOW_BASE_RESET = 16'd1016;
    localparam int unsigned DLAB_BIT          = 7;
    localparam logic [3:0]  IER_MASK          = 4'hF;
    localparam logic [7:0]  FCR_MASK          = 8'hCF;
    localparam logic [4:0]  MCR_MASK          = 5'h1B;
    localparam logic [7:0]  LSR_VALUE         = 8'h60;

    localparam logic [2:0] OFS_DATA = 3'd0;
    localparam logic [2:0] OFS_IER  = 3'd1;
    localparam logic [2:0] OFS_FCR  = 3'd2;
    localparam logic [2:0] OFS_LCR  = 3'd3;
    localparam logic [2:0] OFS_MCR  = 3'd4;
    localparam logic [2:0] OFS_LSR  = 3'd5;
    localparam logic [2:0] OFS_MSR  = 3'd6;
    localparam logic [2:0] OFS_SCR  = 3'd7;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] port_address;
        logic [7:0]  write_data;
    } acc_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       access_error;
    } res_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== src/urf_in_stage.sv =====
// Input register stage: holds one accepted bus access.
module urf_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  urf_pkg::acc_t     acc_in,
    input  logic              advance,
    output logic              item_valid,
    output urf_pkg::acc_t     acc_out
);
    import urf_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    acc_t acc_reg;

    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            acc_reg <= acc_in;
        end
    end

    assign item_valid = in_valid_reg;
    assign acc_out    = acc_reg;

endmodule

// ===== src/urf_regs.sv =====
// Register bank: window decode, register reads and writes, transmit detect.
module urf_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [15:0]       cfg_window_base,
    input  urf_pkg::stage_ctl_t ctl,
    input  urf_pkg::acc_t     acc,
    output urf_pkg::res_t     res
);
    import urf_pkg::*;

    logic [15:0] window_base_reg;
    logic [15:0] divisor_reg;
    logic [15:0] divisor_next;
    logic [3:0]  ier_reg;
    logic [3:0]  ier_next;
    logic [7:0]  fcr_reg;
    logic [7:0]  fcr_next;
    logic [7:0]  lcr_reg;
    logic [7:0]  lcr_next;
    logic [4:0]  mcr_reg;
    logic [4:0]  mcr_next;

    logic [15:0] offset;
    logic [2:0]  ofs;
    logic        in_window;
    logic        dlab;
    logic        commit;
    logic [7:0]  rd_data;
    logic        tx_hit;

    assign offset    = acc.port_address - window_base_reg;
    assign ofs       = offset[2:0];
    assign in_window = (offset[15:3] == '0);
    assign dlab      = lcr_reg[DLAB_BIT];
    assign commit    = ctl.valid && ctl.advance;

    always_comb begin
        rd_data = 8'h00;
        unique case (ofs)
            OFS_DATA: rd_data = dlab ? divisor_reg[7:0] : 8'h00;
            OFS_IER:  rd_data = dlab ? divisor_reg[15:8] : {4'h0, ier_reg};
            OFS_LCR:  rd_data = lcr_reg;
            OFS_MCR:  rd_data = {3'b000, mcr_reg};
            OFS_LSR:  rd_data = LSR_VALUE;
            OFS_FCR, OFS_MSR, OFS_SCR: rd_data = 8'h00;
            default:  rd_data = 8'h00;
        endcase
    end

    always_comb begin
        divisor_next = divisor_reg;
        ier_next     = ier_reg;
        fcr_next     = fcr_reg;
        lcr_next     = lcr_reg;
        mcr_next     = mcr_reg;
        tx_hit       = 1'b0;
        if (in_window && acc.func == FUNC_WRITE) begin
            unique case (ofs)
                OFS_DATA: begin
                    if (dlab) begin
                        divisor_next = {divisor_reg[15:8], acc.write_data};
                    end else begin
                        tx_hit = 1'b1;
                    end
                end
                OFS_IER: begin
                    if (dlab) begin
                        divisor_next = {acc.write_data, divisor_reg[7:0]};
                    end else begin
                        ier_next = acc.write_data[3:0] & IER_MASK;
                    end
                end
                OFS_FCR: fcr_next = acc.write_data & FCR_MASK;
                OFS_LCR: lcr_next = acc.write_data;
                OFS_MCR: mcr_next = acc.write_data[4:0] & MCR_MASK;
                OFS_LSR, OFS_MSR, OFS_SCR: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_base_reg <= WINDOW_BASE_RESET;
            divisor_reg     <= '0;
            ier_reg         <= '0;
            fcr_reg         <= '0;
            lcr_reg         <= '0;
            mcr_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                window_base_reg <= cfg_window_base;
            end
            if (commit) begin
                divisor_reg <= divisor_next;
                ier_reg     <= ier_next;
                fcr_reg     <= fcr_next;
                lcr_reg     <= lcr_next;
                mcr_reg     <= mcr_next;
            end
        end
    end

    always_comb begin
        res.access_error = !in_window;
        res.read_data    = (in_window && acc.func == FUNC_READ) ? rd_data : 8'h00;
        res.tx_valid     = tx_hit;
        res.tx_byte      = tx_hit ? acc.write_data : 8'h00;
    end

endmodule

// ===== src/urf_out_stage.sv =====
// Result register stage: holds one finished word until it is taken.
module urf_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          item_valid,
    input  urf_pkg::res_t res_in,
    output logic          advance,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_read_data,
    output logic          m_tx_valid,
    output logic [7:0]    m_tx_byte,
    output logic          m_access_error
);
    import urf_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    res_t res_reg;

    assign advance        = !out_valid_reg || m_ready;
    assign out_valid_next = advance ? item_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            res_reg <= res_in;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = res_reg.read_data;
    assign m_tx_valid     = res_reg.tx_valid;
    assign m_tx_byte      = res_reg.tx_byte;
    assign m_access_error = res_reg.access_error;

endmodule

// ===== src/uart_8250_register_file.sv =====
// Top level of the 8250 register file: input stage, register bank, result stage.
//
//   channel  direction  handshake              word
//   s_       in         s_valid / s_ready      func, port_address, write_data
//   m_       out        m_valid / m_ready      read_data, tx_valid, tx_byte, access_error
//   cfg_     in         cfg_valid / cfg_ready  window_base
//
// One access per cycle sustained while m_ready is high; m_valid rises once an access
// has gone through the input register, then decode and update into the result register.
// Synchronous active-low reset empties both stages and clears the register bank;
// window base resets to 0x3F8.
// A stalled result holds; the input stage still takes one more word behind it.
module uart_8250_register_file (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_window_base,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_port_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_access_error
);
    import urf_pkg::*;

    acc_t       acc_in;
    acc_t       acc_q;
    res_t       res;
    stage_ctl_t ctl;
    logic       item_valid;
    logic       advance;

    assign cfg_ready           = 1'b1;
    assign acc_in.func         = s_func;
    assign acc_in.port_address = s_port_address;
    assign acc_in.write_data   = s_write_data;
    assign ctl.valid           = item_valid;
    assign ctl.advance         = advance;

    urf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .acc_in     (acc_in),
        .advance    (advance),
        .item_valid (item_valid),
        .acc_out    (acc_q)
    );

    urf_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_window_base (cfg_window_base),
        .ctl             (ctl),
        .acc             (acc_q),
        .res             (res)
    );

    urf_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (item_valid),
        .res_in         (res),
        .advance        (advance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_tx_valid     (m_tx_valid),
        .m_tx_byte      (m_tx_byte),
        .m_access_error (m_access_error)
    );

endmodule

// ===== src/urf_checker.sv =====
// Port-level checks on the 8250 register file, bound to the top level.
`include "uart_8250_register_file_defines.svh"

module urf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_read_data,
    input logic        m_tx_valid,
    input logic [7:0]  m_tx_byte,
    input logic        m_access_error
);

    // hold a stalled result word
    `URF_ASSERT_NXT(a_m_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_read_data) && $stable(m_tx_byte) && $stable(m_access_error))

    // drop everything on an access outside the window
    `URF_ASSERT_IMP(a_err_clean, aclk, aresetn, m_valid && m_access_error,
        !m_tx_valid && m_read_data == 8'h00 && m_tx_byte == 8'h00)

    // a transmit word comes only from an in-window write
    `URF_ASSERT_IMP(a_tx_write, aclk, aresetn, m_valid && m_tx_valid,
        !m_access_error && m_read_data == 8'h00)

    // zero the transmit byte when nothing is sent
    `URF_ASSERT_IMP(a_tx_zero, aclk, aresetn, m_valid && !m_tx_valid, m_tx_byte == 8'h00)

endmodule

bind uart_8250_register_file urf_checker u_urf_checker (.*);

// ===== sim/urf_access_checker.sv =====
// Checker for the 8250 register file: predicts each access and compares the result words.
module urf_access_checker
    import urf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_window_base,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_port_address,
    input  logic [7:0]  s_write_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_read_data,
    input  logic        m_tx_valid,
    input  logic [7:0]  m_tx_byte,
    input  logic        m_access_error,
    output int          mismatches,
    output int          pending,
    output int          compared,
    output int          tx_count,
    output int          outside_count
);

    localparam logic [15:0] WINDOW_PORTS = 16'd8;

    logic [15:0] window_base;
    logic [15:0] divisor;
    logic [3:0]  ier;
    logic [7:0]  fcr;
    logic [7:0]  lcr;
    logic [4:0]  mcr;

    res_t expected_replies[$];
    int   fail_count = 0;
    int   queued = 0;
    int   seen = 0;
    int   tx_seen = 0;
    int   outside_seen = 0;

    assign mismatches    = fail_count;
    assign pending       = queued;
    assign compared      = seen;
    assign tx_count      = tx_seen;
    assign outside_count = outside_seen;

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (fail_count < 40) begin
            $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        end
        fail_count++;
    endtask

    // Decode one access against the register bank and update it.
    task automatic apply_access(input acc_t acc, output res_t reply);
        logic [15:0] offset;
        logic        dlab;
        offset = acc.port_address - window_base;
        dlab   = lcr[DLAB_BIT];
        reply  = '0;
        if (offset >= WINDOW_PORTS) begin
            reply.access_error = 1'b1;
            return;
        end
        if (acc.func == FUNC_READ) begin
            case (offset[2:0])
                OFS_DATA: reply.read_data = dlab ? divisor[7:0] : 8'h00;
                OFS_IER:  reply.read_data = dlab ? divisor[15:8] : {4'h0, ier};
                OFS_LCR:  reply.read_data = lcr;
                OFS_MCR:  reply.read_data = {3'b000, mcr};
                OFS_LSR:  reply.read_data = LSR_VALUE;
                default:  reply.read_data = 8'h00;
            endcase
        end else begin
            case (offset[2:0])
                OFS_DATA: begin
                    if (dlab) begin
                        divisor[7:0] = acc.write_data;
                    end else begin
                        reply.tx_valid = 1'b1;
                        reply.tx_byte  = acc.write_data;
                    end
                end
                OFS_IER: begin
                    if (dlab) begin
                        divisor[15:8] = acc.write_data;
                    end else begin
                        ier = acc.write_data[3:0] & IER_MASK;
                    end
                end
                OFS_FCR: fcr = acc.write_data & FCR_MASK;
                OFS_LCR: lcr = acc.write_data;
                OFS_MCR: mcr = acc.write_data[4:0] & MCR_MASK;
                default: ;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        acc_t acc;
        res_t want;
        if (!aresetn) begin
            window_base = WINDOW_BASE_RESET;
            divisor     = '0;
            ier         = '0;
            fcr         = '0;
            lcr         = '0;
            mcr         = '0;
            expected_replies.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_base = cfg_window_base;
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    flag_mismatch("result word with nothing expected", 1, 0);
                end else begin
                    want = expected_replies.pop_front();
                    seen++;
                    if (m_read_data !== want.read_data) begin
                        flag_mismatch("read_data", m_read_data, want.read_data);
                    end
                    if (m_tx_valid !== want.tx_valid) begin
                        flag_mismatch("tx_valid", m_tx_valid, want.tx_valid);
                    end
                    if (m_tx_byte !== want.tx_byte) begin
                        flag_mismatch("tx_byte", m_tx_byte, want.tx_byte);
                    end
                    if (m_access_error !== want.access_error) begin
                        flag_mismatch("access_error", m_access_error, want.access_error);
                    end
                end
            end
            if (s_valid && s_ready) begin
                acc.func         = s_func;
                acc.port_address = s_port_address;
                acc.write_data   = s_write_data;
                apply_access(acc, want);
                if (want.tx_valid) begin
                    tx_seen++;
                end
                if (want.access_error) begin
                    outside_seen++;
                end
                expected_replies.push_back(want);
            end
        end
        queued <= expected_replies.size();
    end

endmodule

// ===== sim/uart_8250_register_file_tb.sv =====
// Testbench top for the 8250 register file: clock, reset, access stimulus and verdict.
module uart_8250_register_file_tb;
    import urf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_window_base = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = FUNC_READ;
    logic [15:0] s_port_address = '0;
    logic [7:0]  s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_data;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_access_error;

    int          mismatches;
    int          pending;
    int          compared;
    int          tx_count;
    int          outside_count;

    int          send_idle = 0;
    int          recv_idle = 0;
    int          sent = 0;
    int          bases_used = 1;
    int          guard;
    int          seg;
    int unsigned sel;
    logic [15:0] cur_base = WINDOW_BASE_RESET;
    logic [15:0] addr;

    uart_8250_register_file dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_window_base (cfg_window_base),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_port_address  (s_port_address),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_tx_valid      (m_tx_valid),
        .m_tx_byte       (m_tx_byte),
        .m_access_error  (m_access_error)
    );

    urf_access_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_window_base (cfg_window_base),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_port_address  (s_port_address),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_tx_valid      (m_tx_valid),
        .m_tx_byte       (m_tx_byte),
        .m_access_error  (m_access_error),
        .mismatches      (mismatches),
        .pending         (pending),
        .compared        (compared),
        .tx_count        (tx_count),
        .outside_count   (outside_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [15:0] port_at(input logic [2:0] ofs);
        return cur_base + 16'(ofs);
    endfunction

    task automatic send_access(input logic f, input logic [15:0] a, input logic [7:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= f;
        s_port_address <= a;
        s_write_data   <= d;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Hold off until every expected result word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_window_base(input logic [15:0] base);
        cfg_valid       <= 1'b1;
        cfg_window_base <= base;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = base;
        bases_used++;
    endtask

    initial begin
        #2_000_000;
        $display("uart_8250_register_file_tb: FAIL");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset base, every register, DLAB on and off
        send_access(FUNC_READ,  port_at(OFS_LSR),  8'hFF);
        send_access(FUNC_WRITE, port_at(OFS_DATA), 8'h00);
        send_access(FUNC_WRITE, port_at(OFS_DATA), 8'hFF);
        send_access(FUNC_WRITE, port_at(OFS_IER),  8'hFF);
        send_access(FUNC_READ,  port_at(OFS_IER),  8'h00);
        send_access(FUNC_WRITE, port_at(OFS_FCR),  8'hFF);
        send_access(FUNC_READ,  port_at(OFS_FCR),  8'h00);
        send_access(FUNC_WRITE, port_at(OFS_MCR),  8'hFF);
        send_access(FUNC_READ,  port_at(OFS_MCR),  8'h00);
        send_access(FUNC_WRITE, port_at(OFS_LCR),  8'h80);
        send_access(FUNC_WRITE, port_at(OFS_DATA), 8'hA5);
        send_access(FUNC_WRITE, port_at(OFS_IER),  8'h5A);
        send_access(FUNC_READ,  port_at(OFS_DATA), 8'h00);
        send_access(FUNC_READ,  port_at(OFS_IER),  8'h00);
        send_access(FUNC_WRITE, port_at(OFS_LSR),  8'hFF);
        send_access(FUNC_WRITE, port_at(OFS_MSR),  8'hFF);
        send_access(FUNC_WRITE, port_at(OFS_SCR),  8'hFF);
        send_access(FUNC_READ,  port_at(OFS_MSR),  8'h00);
        send_access(FUNC_READ,  port_at(OFS_SCR),  8'h00);
        send_access(FUNC_WRITE, port_at(OFS_LCR),  8'h03);
        send_access(FUNC_READ,  port_at(OFS_LCR),  8'h00);
        send_access(FUNC_READ,  port_at(OFS_DATA), 8'h00);
        send_access(FUNC_READ,  cur_base - 16'd1,  8'h00);
        send_access(FUNC_WRITE, cur_base + 16'd8,  8'hFF);
        send_access(FUNC_WRITE, 16'hFFFF,          8'h00);
        send_access(FUNC_READ,  16'h0000,          8'h00);

        // window that wraps past the top of the port space
        wait_drained();
        write_window_base(16'hFFFC);
        send_access(FUNC_READ,  port_at(OFS_LSR), 8'h00);
        send_access(FUNC_WRITE, port_at(OFS_SCR), 8'h81);
        send_access(FUNC_READ,  16'hFFFB,         8'h00);

        for (seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle = 14;
                    recv_idle = 48;
                end
                1: begin
                    send_idle = 48;
                    recv_idle = 14;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            wait_drained();
            case (seg)
                0:       write_window_base(16'h0000);
                1:       write_window_base(16'hFFFF);
                2:       write_window_base(16'hFFF9);
                3:       write_window_base(WINDOW_BASE_RESET);
                default: write_window_base(16'($urandom));
            endcase
            repeat (240) begin
                sel = $urandom_range(99);
                if (sel < 78) begin
                    addr = port_at(3'($urandom_range(7)));
                end else if (sel < 86) begin
                    addr = cur_base + 16'd8 + 16'($urandom_range(3));
                end else if (sel < 92) begin
                    addr = cur_base - 16'd1 - 16'($urandom_range(3));
                end else begin
                    addr = 16'($urandom);
                end
                send_access(1'($urandom_range(1)), addr, 8'($urandom_range(255)));
            end
        end

        s_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (pending != 0 && guard < 5000);
        repeat (4) @(posedge aclk);

        $display("run covered %0d accesses over %0d port bases, wrapped windows included",
                 sent, bases_used);
        $display("%0d result words compared, %0d transmitted bytes, %0d out-of-window",
                 compared, tx_count, outside_count);
        if (pending != 0) begin
            $display("%0d expected result words never arrived", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("uart_8250_register_file_tb: PASS");
        end else begin
            $display("uart_8250_register_file_tb: FAIL");
        end
        $finish;
    end

endmodule
